// ===== hdl/krtba_pkg.sv =====
// Shared types, constants and microcode for the keyed record table.
`default_nettype none
package krtba_pkg;

   localparam int ENTRIES_DEF       = 64;
   localparam int MEM_ADDR_BITS_DEF = 16;
   localparam int LEN_W             = 17;
   localparam int KEY_W             = 16;
   localparam int CSR_ADDR_W        = 3;

   localparam logic [LEN_W-1:0] MCAP_RESET = 17'h10000;
   localparam logic [6:0]       ICAP_RESET = 7'd64;

   // register select, taken from paddr[2]
   localparam logic REG_MCAP = 1'b0;
   localparam logic REG_ICAP = 1'b1;

   localparam logic [1:0] MODE_KEY  = 2'd0;
   localparam logic [1:0] MODE_SLOT = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [15:0]      key;
      logic [5:0]       slot;
      logic             slot_given;
      logic [LEN_W-1:0] data_len;
      logic [LEN_W-1:0] alloc_len;
   } req_type;

   typedef struct packed {
      logic [5:0]       slot_out;
      logic             ok;
      logic [15:0]      base_offset;
      logic [LEN_W-1:0] reserved_len;
      logic [LEN_W-1:0] used_len;
      logic [15:0]      entry_key;
      logic             fresh;
      logic [6:0]       count_out;
   } rsp_type;

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_FAIL   = 4'd2;
   localparam logic [3:0] OP_RDSCAN = 4'd3;
   localparam logic [3:0] OP_SCAN   = 4'd4;
   localparam logic [3:0] OP_ALLOC  = 4'd5;
   localparam logic [3:0] OP_HIT    = 4'd6;
   localparam logic [3:0] OP_RDSLOT = 4'd7;
   localparam logic [3:0] OP_WRUSED = 4'd8;
   localparam logic [3:0] OP_RDRES  = 4'd9;
   localparam logic [3:0] OP_EMIT   = 4'd10;

   // branch conditions
   localparam logic [3:0] C_NEVER    = 4'd0;
   localparam logic [3:0] C_ALWAYS   = 4'd1;
   localparam logic [3:0] C_NOREQ    = 4'd2;
   localparam logic [3:0] C_MODE0    = 4'd3;
   localparam logic [3:0] C_MODE1    = 4'd4;
   localparam logic [3:0] C_MODE2    = 4'd5;
   localparam logic [3:0] C_CNTZERO  = 4'd6;
   localparam logic [3:0] C_MATCH    = 4'd7;
   localparam logic [3:0] C_MORE     = 4'd8;
   localparam logic [3:0] C_NOGIVEN  = 4'd9;
   localparam logic [3:0] C_BADSLOT  = 4'd10;
   localparam logic [3:0] C_OUTFREE  = 4'd11;

   // program steps
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DISP0   = 4'd1;
   localparam logic [3:0] S_DISP1   = 4'd2;
   localparam logic [3:0] S_DISP2   = 4'd3;
   localparam logic [3:0] S_FAIL    = 4'd4;
   localparam logic [3:0] S_PRIME   = 4'd5;
   localparam logic [3:0] S_LOOP    = 4'd6;
   localparam logic [3:0] S_ALLOC   = 4'd7;
   localparam logic [3:0] S_HIT     = 4'd8;
   localparam logic [3:0] S_GIVEN   = 4'd9;
   localparam logic [3:0] S_RDSLOT1 = 4'd10;
   localparam logic [3:0] S_WRUSED  = 4'd11;
   localparam logic [3:0] S_RDSLOT2 = 4'd12;
   localparam logic [3:0] S_RDRES   = 4'd13;
   localparam logic [3:0] S_EMIT    = 4'd14;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] jmp_cond;
      logic [3:0] jmp_to;
      logic [3:0] hold_cond;
   } ucode_type;

   typedef struct packed {
      logic noreq;
      logic mode0;
      logic mode1;
      logic mode2;
      logic cnt_zero;
      logic match;
      logic more;
      logic no_given;
      logic bad_slot;
      logic out_free;
   } flags_type;

   typedef struct packed {
      logic [3:0] op;
      logic       idle;
   } ctl_type;

   // control store: jump if jmp_cond, else stay if hold_cond, else next step
   function automatic ucode_type rom_word(input logic [3:0] step);
      ucode_type w;
      w = '{op: OP_NONE, jmp_cond: C_ALWAYS, jmp_to: S_IDLE, hold_cond: C_NEVER};
      case (step)
         S_IDLE:    w = '{op: OP_LOAD,   jmp_cond: C_NOREQ,   jmp_to: S_IDLE,
                          hold_cond: C_NEVER};
         S_DISP0:   w = '{op: OP_NONE,   jmp_cond: C_MODE0,   jmp_to: S_PRIME,
                          hold_cond: C_NEVER};
         S_DISP1:   w = '{op: OP_NONE,   jmp_cond: C_MODE1,   jmp_to: S_GIVEN,
                          hold_cond: C_NEVER};
         S_DISP2:   w = '{op: OP_NONE,   jmp_cond: C_MODE2,   jmp_to: S_RDSLOT2,
                          hold_cond: C_NEVER};
         S_FAIL:    w = '{op: OP_FAIL,   jmp_cond: C_ALWAYS,  jmp_to: S_EMIT,
                          hold_cond: C_NEVER};
         S_PRIME:   w = '{op: OP_RDSCAN, jmp_cond: C_CNTZERO, jmp_to: S_ALLOC,
                          hold_cond: C_NEVER};
         S_LOOP:    w = '{op: OP_SCAN,   jmp_cond: C_MATCH,   jmp_to: S_HIT,
                          hold_cond: C_MORE};
         S_ALLOC:   w = '{op: OP_ALLOC,  jmp_cond: C_ALWAYS,  jmp_to: S_EMIT,
                          hold_cond: C_NEVER};
         S_HIT:     w = '{op: OP_HIT,    jmp_cond: C_ALWAYS,  jmp_to: S_EMIT,
                          hold_cond: C_NEVER};
         S_GIVEN:   w = '{op: OP_NONE,   jmp_cond: C_NOGIVEN, jmp_to: S_ALLOC,
                          hold_cond: C_NEVER};
         S_RDSLOT1: w = '{op: OP_RDSLOT, jmp_cond: C_BADSLOT, jmp_to: S_FAIL,
                          hold_cond: C_NEVER};
         S_WRUSED:  w = '{op: OP_WRUSED, jmp_cond: C_ALWAYS,  jmp_to: S_EMIT,
                          hold_cond: C_NEVER};
         S_RDSLOT2: w = '{op: OP_RDSLOT, jmp_cond: C_BADSLOT, jmp_to: S_FAIL,
                          hold_cond: C_NEVER};
         S_RDRES:   w = '{op: OP_RDRES,  jmp_cond: C_ALWAYS,  jmp_to: S_EMIT,
                          hold_cond: C_NEVER};
         S_EMIT:    w = '{op: OP_EMIT,   jmp_cond: C_OUTFREE, jmp_to: S_IDLE,
                          hold_cond: C_ALWAYS};
         default:   w = '{op: OP_NONE,   jmp_cond: C_ALWAYS,  jmp_to: S_IDLE,
                          hold_cond: C_NEVER};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/krtba_mem.sv =====
// Record memory: one write port, one registered read port.
`default_nettype none
module krtba_mem #(
   parameter int DEPTH = krtba_pkg::ENTRIES_DEF,
   parameter int WIDTH = 67
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/krtba_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none
module krtba_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire krtba_pkg::flags_type  flags,
   output krtba_pkg::ctl_type         ctl
);

   logic [3:0]           step_ff;
   logic [3:0]           step_in;
   krtba_pkg::ucode_type word;

   function automatic logic cond_true(input logic [3:0] c,
                                      input krtba_pkg::flags_type f);
      logic r;
      r = 1'b0;
      case (c)
         krtba_pkg::C_NEVER:   r = 1'b0;
         krtba_pkg::C_ALWAYS:  r = 1'b1;
         krtba_pkg::C_NOREQ:   r = f.noreq;
         krtba_pkg::C_MODE0:   r = f.mode0;
         krtba_pkg::C_MODE1:   r = f.mode1;
         krtba_pkg::C_MODE2:   r = f.mode2;
         krtba_pkg::C_CNTZERO: r = f.cnt_zero;
         krtba_pkg::C_MATCH:   r = f.match;
         krtba_pkg::C_MORE:    r = f.more;
         krtba_pkg::C_NOGIVEN: r = f.no_given;
         krtba_pkg::C_BADSLOT: r = f.bad_slot;
         krtba_pkg::C_OUTFREE: r = f.out_free;
         default:              r = 1'b0;
      endcase
      return r;
   endfunction

   always_comb begin
      word = krtba_pkg::rom_word(step_ff);
      if (cond_true(word.jmp_cond, flags)) begin
         step_in = word.jmp_to;
      end else if (cond_true(word.hold_cond, flags)) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= krtba_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctl.op   = word.op;
   assign ctl.idle = (step_ff == krtba_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/keyed_record_table_bump_alloc.sv =====
// Keyed record table with bump allocator over a shared record memory.
//
// Requests arrive on req_valid/req_stall/req_data and one result per request
// leaves on rsp_valid/rsp_stall/rsp_data. One request is worked on at a time;
// req_stall is low only while the sequencer waits in its idle step.
// Steps from accept to the result register, with n allocated entries:
//   key write, new key      dispatch, read of entry 0, scan of n, alloc
//   key write, hit at k     dispatch, read of entry 0, scan to k, hit
//   slot write / read       dispatch, slot read, write or read-out; fail
//   on a bad slot; slot-less allocation goes to alloc, unused mode to fail.
// The key search reads the record memory one entry per cycle through its
// single read port, so that loop sets the worst case; the next request is
// taken in the idle cycle after the result is loaded.
// The result sits in an output register; the sequencer holds its last step
// while rsp_stall keeps that register full, then returns to idle.
// Reset empties the table (entry count and fill level to zero) and loads
// mem_capacity = 65536 and index_capacity = 64; no clearing pass is needed,
// since an entry is written in full when it is allocated.
// Configuration goes through the APB-style csr_ port, registers at 0 and 4.
`default_nettype none
module keyed_record_table_bump_alloc #(
   parameter int ENTRIES       = krtba_pkg::ENTRIES_DEF,
   parameter int MEM_ADDR_BITS = krtba_pkg::MEM_ADDR_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire krtba_pkg::req_type                   req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output krtba_pkg::rsp_type                        rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [krtba_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic      [31:0]                          csr_prdata,
   output logic                                      csr_pready
);

   localparam int LW     = krtba_pkg::LEN_W;
   localparam int KW     = krtba_pkg::KEY_W;
   localparam int IW     = $clog2(ENTRIES);
   localparam int CW     = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CW > 6) ? CW : 6;
   localparam int CAP_W  = (CW > 7) ? CW : 7;
   localparam int WORD_W = KW + MEM_ADDR_BITS + LW + LW + 1;
   localparam int USED_LO = 1;
   localparam int RESV_LO = USED_LO + LW;
   localparam int BASE_LO = RESV_LO + LW;
   localparam int KEY_LO  = BASE_LO + MEM_ADDR_BITS;
   localparam logic [32:0] BASE_MAX = (33'd1 << MEM_ADDR_BITS) - 33'd1;

   // configuration
   logic [LW-1:0] mcap_ff;
   logic [6:0]    icap_ff;
   logic          csr_wr;

   // table state and item registers
   krtba_pkg::req_type item_ff;
   krtba_pkg::rsp_type res_ff, res_in;
   krtba_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [LW-1:0]      mem_used_ff, mem_used_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      rd_idx_ff;

   krtba_pkg::flags_type flags;
   krtba_pkg::ctl_type   ctl;

   // memory port signals
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_word;

   logic [KW-1:0]            rd_key;
   logic [MEM_ADDR_BITS-1:0] rd_base;
   logic [LW-1:0]            rd_resv;
   logic [LW-1:0]            rd_used;

   logic          req_accept;
   logic          out_free;
   logic [LW-1:0] alen;
   logic [LW:0]   alloc_end;
   logic          alloc_ok;
   logic [CW-1:0] count_inc;
   logic [LW-1:0] new_used;

   assign rd_key  = rd_word[KEY_LO +: KW];
   assign rd_base = rd_word[BASE_LO +: MEM_ADDR_BITS];
   assign rd_resv = rd_word[RESV_LO +: LW];
   assign rd_used = rd_word[USED_LO +: LW];

   assign req_stall  = !ctl.idle;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_inc  = count_ff + CW'(1);

   // allocation check: table limit, memory limit, base addressable
   assign alen      = (item_ff.mode == krtba_pkg::MODE_KEY) ? item_ff.data_len
                                                            : item_ff.alloc_len;
   assign alloc_end = {1'b0, mem_used_ff} + {1'b0, alen};
   assign new_used  = (item_ff.mode == krtba_pkg::MODE_SLOT) ? item_ff.data_len
                                                             : '0;
   assign alloc_ok  = (CAP_W'(count_ff) < CAP_W'(icap_ff))
                   && (count_ff < CW'(ENTRIES))
                   && (alloc_end <= {1'b0, mcap_ff})
                   && ({16'd0, mem_used_ff} <= BASE_MAX);

   assign flags.noreq    = !req_valid;
   assign flags.mode0    = (item_ff.mode == krtba_pkg::MODE_KEY);
   assign flags.mode1    = (item_ff.mode == krtba_pkg::MODE_SLOT);
   assign flags.mode2    = (item_ff.mode == krtba_pkg::MODE_READ);
   assign flags.cnt_zero = (count_ff == '0);
   assign flags.match    = (rd_key == item_ff.key);
   assign flags.more     = (idx_ff < count_ff);
   assign flags.no_given = !item_ff.slot_given;
   assign flags.bad_slot = !(CMP_W'(item_ff.slot) < CMP_W'(count_ff));
   assign flags.out_free = out_free;

   krtba_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   krtba_mem #(
      .DEPTH (ENTRIES),
      .WIDTH (WORD_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_data     = rd_word;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[IW-1:0];
      idx_in      = idx_ff;
      count_in    = count_ff;
      mem_used_in = mem_used_ff;
      res_in      = res_ff;
      case (ctl.op)
         krtba_pkg::OP_LOAD: begin
            idx_in = '0;
         end
         krtba_pkg::OP_FAIL: begin
            res_in           = '0;
            res_in.count_out = 7'(count_ff);
         end
         krtba_pkg::OP_RDSCAN: begin
            rd_en  = 1'b1;
            idx_in = idx_ff + CW'(1);
         end
         krtba_pkg::OP_SCAN: begin
            // keep the matching entry in the read register
            if (!flags.match && flags.more) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
         end
         krtba_pkg::OP_ALLOC: begin
            if (alloc_ok) begin
               wr_en       = 1'b1;
               wr_addr     = count_ff[IW-1:0];
               wr_data     = {item_ff.key, MEM_ADDR_BITS'(mem_used_ff), alen,
                              new_used, 1'b1};
               count_in    = count_inc;
               mem_used_in = alloc_end[LW-1:0];
               res_in.slot_out     = 6'(count_ff);
               res_in.ok           = 1'b1;
               res_in.base_offset  = 16'(mem_used_ff);
               res_in.reserved_len = alen;
               res_in.used_len     = new_used;
               res_in.entry_key    = item_ff.key;
               res_in.fresh        = 1'b1;
               res_in.count_out    = 7'(count_inc);
            end else begin
               res_in           = '0;
               res_in.count_out = 7'(count_ff);
            end
         end
         krtba_pkg::OP_HIT: begin
            wr_en      = 1'b1;
            wr_data    = {rd_word[WORD_W-1:1], 1'b1};
            res_in.slot_out     = 6'(rd_idx_ff);
            res_in.ok           = 1'b1;
            res_in.base_offset  = 16'(rd_base);
            res_in.reserved_len = rd_resv;
            res_in.used_len     = rd_used;
            res_in.entry_key    = rd_key;
            res_in.fresh        = 1'b1;
            res_in.count_out    = 7'(count_ff);
         end
         krtba_pkg::OP_RDSLOT: begin
            rd_en   = 1'b1;
            rd_addr = IW'(item_ff.slot);
         end
         krtba_pkg::OP_WRUSED: begin
            wr_en      = 1'b1;
            wr_data    = {rd_word[WORD_W-1:RESV_LO], item_ff.data_len, 1'b1};
            res_in.slot_out     = 6'(rd_idx_ff);
            res_in.ok           = 1'b1;
            res_in.base_offset  = 16'(rd_base);
            res_in.reserved_len = rd_resv;
            res_in.used_len     = item_ff.data_len;
            res_in.entry_key    = rd_key;
            res_in.fresh        = 1'b1;
            res_in.count_out    = 7'(count_ff);
         end
         krtba_pkg::OP_RDRES: begin
            res_in.slot_out     = 6'(rd_idx_ff);
            res_in.ok           = 1'b1;
            res_in.base_offset  = 16'(rd_base);
            res_in.reserved_len = rd_resv;
            res_in.used_len     = rd_used;
            res_in.entry_key    = rd_key;
            res_in.fresh        = rd_word[0];
            res_in.count_out    = 7'(count_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         mem_used_ff <= '0;
      end else begin
         count_ff    <= count_in;
         mem_used_ff <= mem_used_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      res_ff <= res_in;
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.op == krtba_pkg::OP_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == krtba_pkg::OP_EMIT && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mcap_ff <= krtba_pkg::MCAP_RESET;
         icap_ff <= krtba_pkg::ICAP_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == krtba_pkg::REG_MCAP) begin
            mcap_ff <= csr_pwdata[LW-1:0];
         end else begin
            icap_ff <= csr_pwdata[6:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr[2])
         krtba_pkg::REG_MCAP: csr_prdata = 32'(mcap_ff);
         krtba_pkg::REG_ICAP: csr_prdata = 32'(icap_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // the table never holds more entries than it has rows
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count beyond table depth");

   // entries are only ever added one at a time
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count moved by other than one");

   // a result appears only from the emit step
   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.op == krtba_pkg::OP_EMIT))
      else $error("result raised outside emit step");

   // no new request is taken while a table write is in flight
   a_no_accept_on_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !req_accept)
      else $error("request accepted during table write");

endmodule
`default_nettype wire
